[hdl/skbt_pkg.sv]
package skbt_pkg;

    // Wide signed type that holds any intermediate sum before clamping
    localparam int WIDE_W = 72;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam wide_t S32_MAX_W = 72'sd2147483647;
    localparam wide_t S32_MIN_W = -72'sd2147483648;
    localparam wide_t U31_MAX_W = 72'sd2147483647;
    localparam wide_t ZERO_W    = 72'sd0;

    // Configuration register indexes
    localparam logic [1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [1:0] REG_INITIAL_VARIANCE  = 2'd2;

    // Register reset values, unsigned Q7.24
    localparam logic [30:0] PROCESS_NOISE_RST     = 31'd33554;
    localparam logic [30:0] MEASUREMENT_NOISE_RST = 31'd50332;
    localparam logic [30:0] INITIAL_VARIANCE_RST  = 31'd41943;

    // Item function codes
    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
    localparam logic [1:0] STATUS_SAT      = 2'd2;

    // Divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic sat;
    } div_stat_t;

    function automatic logic signed [31:0] sat_s32(input wide_t v);
        logic signed [31:0] r;
        if (v > S32_MAX_W) begin
            r = 32'sh7fff_ffff;
        end else if (v < S32_MIN_W) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    function automatic logic ovf_s32(input wide_t v);
        return (v > S32_MAX_W) || (v < S32_MIN_W);
    endfunction

    function automatic logic [30:0] sat_u31(input wide_t v);
        logic [30:0] r;
        if (v > U31_MAX_W) begin
            r = 31'h7fff_ffff;
        end else if (v < ZERO_W) begin
            r = 31'd0;
        end else begin
            r = 31'(v);
        end
        return r;
    endfunction

    function automatic logic ovf_u31(input wide_t v);
        return (v > U31_MAX_W) || (v < ZERO_W);
    endfunction

endpackage

[hdl/skbt_mul.sv]
module skbt_mul (
    input  logic               aclk,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [63:0] prod
);

    logic signed [63:0] prod_reg;

    // Register the full signed product
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

[hdl/skbt_div.sv]
module skbt_div #(
    parameter int FRAC_BITS = 24,
    parameter int DEN_W     = 40
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [31:0]             num_mag,
    input  logic                    num_neg,
    input  logic [DEN_W-1:0]        den,
    output logic signed [31:0]      quot,
    output skbt_pkg::div_stat_t     stat
);

    // Dividend is |num| scaled by 2^FRAC_BITS; quotient bits are found one a cycle
    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int QB    = 33;
    localparam int HI_W  = NUM_W - QB;
    localparam int CNT_W = $clog2(QB + 1);

    logic [NUM_W-1:0]      num_full;
    logic [DEN_W-1:0]      num_hi;
    logic [DEN_W:0]        trial;
    logic                  qbit;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DEN_W-1:0]      rem_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [QB-1:0]         nlow_reg;
    logic [QB-1:0]         q_reg;
    logic                  neg_reg;
    logic                  ovf_reg;
    logic                  sat_reg;
    logic signed [31:0]    quot_reg;

    assign num_full = {num_mag, FRAC_BITS'(0)};
    assign num_hi   = DEN_W'(num_full[NUM_W-1 -: HI_W]);
    assign trial    = {rem_reg, nlow_reg[QB-1]};
    assign qbit     = (trial >= {1'b0, den_reg});

    // Control: load, step through the quotient bits, then finish
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CNT_W'(QB)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Datapath: restoring division, then sign and clamp
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg  <= den;
            neg_reg  <= num_neg;
            ovf_reg  <= (num_hi >= den);
            rem_reg  <= (num_hi >= den) ? '0 : num_hi;
            nlow_reg <= num_full[QB-1:0];
            q_reg    <= '0;
        end else if (busy_reg && (cnt_reg != CNT_W'(QB))) begin
            rem_reg  <= qbit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            q_reg    <= {q_reg[QB-2:0], qbit};
            nlow_reg <= {nlow_reg[QB-2:0], 1'b0};
        end else if (busy_reg) begin
            if (!neg_reg) begin
                if (ovf_reg || (q_reg > QB'(32'h7fff_ffff))) begin
                    sat_reg  <= 1'b1;
                    quot_reg <= 32'sh7fff_ffff;
                end else begin
                    sat_reg  <= 1'b0;
                    quot_reg <= 32'(q_reg);
                end
            end else begin
                if (ovf_reg || (q_reg > QB'(32'h8000_0000))) begin
                    sat_reg  <= 1'b1;
                    quot_reg <= 32'sh8000_0000;
                end else begin
                    sat_reg  <= 1'b0;
                    quot_reg <= 32'(~q_reg + 1'b1);
                end
            end
        end
    end

    assign quot      = quot_reg;
    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;

endmodule

[hdl/scalar_kalman_beta_tracker_core.sv]
// Channel   Direction  Ports                    Content
// s_        in         tvalid tready tdata tuser  tuser[0] func; tdata beta0/asset/market/rf
// m_        out        tvalid tready tdata tuser  tdata beta/variance; tuser status
// cfg_      in         we index wdata           Q, R, P0 register writes
//
// A start item goes straight to the output load; an update forms nine products on
// one shared 32x32 multiplier and the gain in the bit-serial divider, then loads the
// output (the divider is skipped when the denominator is zero).
// Reset (aresetn low, synchronous) clears beta and variance to zero and loads
// the register defaults. The input is ready only when the sequencer is idle; a
// finished result waits in the output register while the next item is taken.
module scalar_kalman_beta_tracker_core #(
    parameter int FRAC_BITS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    // tdata: initial_beta[31:0], asset_return[63:32], market_return[95:64],
    //        riskfree_rate[127:96]
    input  logic [127:0] s_tdata,
    // tuser: func[0]
    input  logic [0:0]   s_tuser,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: beta_estimate[31:0], variance_estimate[62:32], zero pad[63]
    output logic [63:0]  m_tdata,
    // tuser: status[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_wdata
);

    localparam int FL_W = 64 - FRAC_BITS;
    localparam skbt_pkg::wide_t ONE_W = skbt_pkg::wide_t'(1) <<< FRAC_BITS;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_M1   = 5'd1;
    localparam logic [4:0] ST_M1W  = 5'd2;
    localparam logic [4:0] ST_M2   = 5'd3;
    localparam logic [4:0] ST_M2W  = 5'd4;
    localparam logic [4:0] ST_M3   = 5'd5;
    localparam logic [4:0] ST_M3W  = 5'd6;
    localparam logic [4:0] ST_DIVS = 5'd7;
    localparam logic [4:0] ST_DIVW = 5'd8;
    localparam logic [4:0] ST_M4   = 5'd9;
    localparam logic [4:0] ST_M4W  = 5'd10;
    localparam logic [4:0] ST_M5   = 5'd11;
    localparam logic [4:0] ST_M5W  = 5'd12;
    localparam logic [4:0] ST_M6   = 5'd13;
    localparam logic [4:0] ST_M6W  = 5'd14;
    localparam logic [4:0] ST_M7   = 5'd15;
    localparam logic [4:0] ST_M7W  = 5'd16;
    localparam logic [4:0] ST_M8   = 5'd17;
    localparam logic [4:0] ST_M8W  = 5'd18;
    localparam logic [4:0] ST_M9   = 5'd19;
    localparam logic [4:0] ST_M9W  = 5'd20;
    localparam logic [4:0] ST_FIN  = 5'd21;

    logic [4:0]               state_reg;
    logic [4:0]               state_next;

    logic [30:0]              q_reg;
    logic [30:0]              r_reg;
    logic [30:0]              p0_reg;

    logic signed [31:0]       beta_reg;
    logic [30:0]              var_reg;

    logic signed [31:0]       x_reg;
    logic signed [31:0]       y_reg;
    logic [30:0]              pm_reg;
    logic signed [31:0]       eps_reg;
    logic signed [31:0]       px_reg;
    logic [FL_W-1:0]          den_reg;
    logic signed [31:0]       k_reg;
    logic signed [31:0]       om_reg;
    logic signed [31:0]       sq_reg;
    logic signed [31:0]       ksq_reg;
    logic signed [FL_W-1:0]   acc_reg;
    logic                     sat_reg;
    logic                     zden_reg;

    logic                     m_tvalid_reg;
    logic signed [31:0]       beta_out_reg;
    logic [30:0]              var_out_reg;
    logic [1:0]               status_out_reg;

    logic signed [31:0]       in_beta;
    logic signed [31:0]       in_asset;
    logic signed [31:0]       in_market;
    logic signed [31:0]       in_rf;
    logic                     in_accept;

    skbt_pkg::wide_t          x_wide;
    skbt_pkg::wide_t          y_wide;
    skbt_pkg::wide_t          pm_wide;
    skbt_pkg::wide_t          kx_wide;
    logic signed [31:0]       kx_sat;
    skbt_pkg::wide_t          om_wide;

    logic signed [31:0]       mul_a;
    logic signed [31:0]       mul_b;
    logic signed [63:0]       prod;
    logic signed [FL_W-1:0]   fl_val;
    skbt_pkg::wide_t          fl_wide;

    logic                     div_start;
    logic [31:0]              div_mag;
    logic signed [31:0]       div_quot;
    skbt_pkg::div_stat_t      div_stat;

    logic                     out_load;

    assign in_beta   = $signed(s_tdata[31:0]);
    assign in_asset  = $signed(s_tdata[63:32]);
    assign in_market = $signed(s_tdata[95:64]);
    assign in_rf     = $signed(s_tdata[127:96]);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Excess returns and predicted variance, formed as the item is taken
    assign x_wide  = skbt_pkg::wide_t'(in_market) - skbt_pkg::wide_t'(in_rf);
    assign y_wide  = skbt_pkg::wide_t'(in_asset) - skbt_pkg::wide_t'(in_rf);
    assign pm_wide = skbt_pkg::wide_t'({1'b0, var_reg}) + skbt_pkg::wide_t'({1'b0, q_reg});

    // Floor-scaled product of the shared multiplier
    assign fl_val  = FL_W'(prod >>> FRAC_BITS);
    assign fl_wide = skbt_pkg::wide_t'(fl_val);

    // One minus K*x, both steps clamped
    assign kx_wide = fl_wide;
    assign kx_sat  = skbt_pkg::sat_s32(kx_wide);
    assign om_wide = ONE_W - skbt_pkg::wide_t'(kx_sat);

    // Select multiplier operands for each product
    always_comb begin
        mul_a = beta_reg;
        mul_b = x_reg;
        case (state_reg)
            ST_M1: begin
                mul_a = beta_reg;
                mul_b = x_reg;
            end
            ST_M2: begin
                mul_a = $signed({1'b0, pm_reg});
                mul_b = x_reg;
            end
            ST_M3: begin
                mul_a = px_reg;
                mul_b = x_reg;
            end
            ST_M4: begin
                mul_a = k_reg;
                mul_b = eps_reg;
            end
            ST_M5: begin
                mul_a = k_reg;
                mul_b = x_reg;
            end
            ST_M6: begin
                mul_a = om_reg;
                mul_b = om_reg;
            end
            ST_M7: begin
                mul_a = k_reg;
                mul_b = k_reg;
            end
            ST_M8: begin
                mul_a = sq_reg;
                mul_b = $signed({1'b0, pm_reg});
            end
            ST_M9: begin
                mul_a = ksq_reg;
                mul_b = $signed({1'b0, r_reg});
            end
            default: begin
                mul_a = beta_reg;
                mul_b = x_reg;
            end
        endcase
    end

    skbt_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Gain division: |px| * 2^FRAC_BITS / den
    assign div_start = (state_reg == ST_DIVS) && (den_reg != '0);
    assign div_mag   = px_reg[31] ? 32'(-px_reg) : 32'(px_reg);

    skbt_div #(
        .FRAC_BITS (FRAC_BITS),
        .DEN_W     (FL_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_mag (div_mag),
        .num_neg (px_reg[31]),
        .den     (den_reg),
        .quot    (div_quot),
        .stat    (div_stat)
    );

    assign out_load = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = (s_tuser[0] == skbt_pkg::FUNC_START) ? ST_FIN : ST_M1;
                end
            end
            ST_M1:   state_next = ST_M1W;
            ST_M1W:  state_next = ST_M2;
            ST_M2:   state_next = ST_M2W;
            ST_M2W:  state_next = ST_M3;
            ST_M3:   state_next = ST_M3W;
            ST_M3W:  state_next = ST_DIVS;
            ST_DIVS: state_next = (den_reg == '0) ? ST_M4 : ST_DIVW;
            ST_DIVW: begin
                if (div_stat.done) begin
                    state_next = ST_M4;
                end
            end
            ST_M4:   state_next = ST_M4W;
            ST_M4W:  state_next = ST_M5;
            ST_M5:   state_next = ST_M5W;
            ST_M5W:  state_next = ST_M6;
            ST_M6:   state_next = ST_M6W;
            ST_M6W:  state_next = ST_M7;
            ST_M7:   state_next = ST_M7W;
            ST_M7W:  state_next = ST_M8;
            ST_M8:   state_next = ST_M8W;
            ST_M8W:  state_next = ST_M9;
            ST_M9:   state_next = ST_M9W;
            ST_M9W:  state_next = ST_FIN;
            ST_FIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            q_reg        <= skbt_pkg::PROCESS_NOISE_RST;
            r_reg        <= skbt_pkg::MEASUREMENT_NOISE_RST;
            p0_reg       <= skbt_pkg::INITIAL_VARIANCE_RST;
            beta_reg     <= '0;
            var_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            sat_reg      <= 1'b0;
            zden_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_index)
                    skbt_pkg::REG_PROCESS_NOISE:     q_reg  <= cfg_wdata;
                    skbt_pkg::REG_MEASUREMENT_NOISE: r_reg  <= cfg_wdata;
                    skbt_pkg::REG_INITIAL_VARIANCE:  p0_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        zden_reg <= 1'b0;
                        if (s_tuser[0] == skbt_pkg::FUNC_START) begin
                            beta_reg <= in_beta;
                            var_reg  <= p0_reg;
                            sat_reg  <= 1'b0;
                        end else begin
                            sat_reg <= skbt_pkg::ovf_s32(x_wide) || skbt_pkg::ovf_s32(y_wide)
                                       || skbt_pkg::ovf_u31(pm_wide);
                        end
                    end
                end
                ST_M1W: begin
                    sat_reg <= sat_reg
                               || skbt_pkg::ovf_s32(skbt_pkg::wide_t'(y_reg) - fl_wide);
                end
                ST_M2W: begin
                    sat_reg <= sat_reg || skbt_pkg::ovf_s32(fl_wide);
                end
                ST_DIVS: begin
                    if (den_reg == '0) begin
                        zden_reg <= 1'b1;
                    end
                end
                ST_DIVW: begin
                    if (div_stat.done) begin
                        sat_reg <= sat_reg || div_stat.sat;
                    end
                end
                ST_M4W: begin
                    beta_reg <= skbt_pkg::sat_s32(skbt_pkg::wide_t'(beta_reg) + fl_wide);
                    sat_reg  <= sat_reg
                                || skbt_pkg::ovf_s32(skbt_pkg::wide_t'(beta_reg) + fl_wide);
                end
                ST_M5W: begin
                    sat_reg <= sat_reg || skbt_pkg::ovf_s32(kx_wide)
                               || skbt_pkg::ovf_s32(om_wide);
                end
                ST_M6W, ST_M7W: begin
                    sat_reg <= sat_reg || skbt_pkg::ovf_s32(fl_wide);
                end
                ST_M9W: begin
                    var_reg <= skbt_pkg::sat_u31(skbt_pkg::wide_t'(acc_reg) + fl_wide);
                    sat_reg <= sat_reg
                               || skbt_pkg::ovf_u31(skbt_pkg::wide_t'(acc_reg) + fl_wide);
                end
                default: ;
            endcase
        end
    end

    // Working values of the update
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                x_reg  <= skbt_pkg::sat_s32(x_wide);
                y_reg  <= skbt_pkg::sat_s32(y_wide);
                pm_reg <= skbt_pkg::sat_u31(pm_wide);
            end
            ST_M1W:  eps_reg <= skbt_pkg::sat_s32(skbt_pkg::wide_t'(y_reg) - fl_wide);
            ST_M2W:  px_reg  <= skbt_pkg::sat_s32(fl_wide);
            ST_M3W:  den_reg <= $unsigned(fl_val) + FL_W'(r_reg);
            ST_DIVS: k_reg   <= '0;
            ST_DIVW: begin
                if (div_stat.done) begin
                    k_reg <= div_quot;
                end
            end
            ST_M5W:  om_reg  <= skbt_pkg::sat_s32(om_wide);
            ST_M6W:  sq_reg  <= skbt_pkg::sat_s32(fl_wide);
            ST_M7W:  ksq_reg <= skbt_pkg::sat_s32(fl_wide);
            ST_M8W:  acc_reg <= fl_val;
            default: ;
        endcase
    end

    // Hold the result until the item is taken
    always_ff @(posedge aclk) begin
        if (out_load) begin
            beta_out_reg <= beta_reg;
            var_out_reg  <= var_reg;
            if (sat_reg) begin
                status_out_reg <= skbt_pkg::STATUS_SAT;
            end else if (zden_reg) begin
                status_out_reg <= skbt_pkg::STATUS_ZERO_DEN;
            end else begin
                status_out_reg <= skbt_pkg::STATUS_OK;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, var_out_reg, beta_out_reg};
    assign m_tuser  = status_out_reg;

endmodule
